>>> sv/btpc_pkg.sv
`timescale 1ns / 1ps
package btpc_pkg;

   localparam int unsigned Oversampling = 0;
   localparam logic [1:0] OSS_BITS = Oversampling[1:0];

   localparam logic [3:0] REG_AC1 = 4'd0;
   localparam logic [3:0] REG_AC2 = 4'd1;
   localparam logic [3:0] REG_AC3 = 4'd2;
   localparam logic [3:0] REG_AC4 = 4'd3;
   localparam logic [3:0] REG_B1  = 4'd4;
   localparam logic [3:0] REG_B2  = 4'd5;
   localparam logic [3:0] REG_AC56 = 4'd6;
   localparam logic [3:0] REG_MCMD = 4'd7;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_T_X1,
      ST_T_D,
      ST_T_DIV,
      ST_T_B5,
      ST_P_B6,
      ST_P_SQ,
      ST_P_X1,
      ST_P_X2,
      ST_P_B3,
      ST_P_Y1,
      ST_P_Y2,
      ST_P_X3,
      ST_P_B4,
      ST_P_B7,
      ST_P_DIV,
      ST_P_Q,
      ST_P_Z1,
      ST_P_Z2,
      ST_P_Z3,
      ST_P_Z4,
      ST_P_FIN,
      ST_OUT
   } state_type;

   typedef struct packed {
      state_type step;
      logic      div_start;
      logic      load_req;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic div_zero;
   } status_type;

endpackage

>>> sv/btpc_div.sv
`timescale 1ns / 1ps
module btpc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic [31:0] quotient,
   output logic        done
);
   logic [31:0] q_ff, q_in;
   logic [31:0] r_ff, r_in;
   logic [31:0] d_ff, d_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {r_ff, q_ff[31]} - {1'b0, d_ff};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
         cnt_in = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            r_in = trial[31:0];
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = {r_ff[30:0], q_ff[31]};
            q_in = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign quotient = q_ff;
   assign done = busy_ff && (cnt_ff == 6'd1);
endmodule

>>> sv/btpc_ctrl.sv
`timescale 1ns / 1ps
module btpc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   req_func,
   input  btpc_pkg::status_type   status,
   output btpc_pkg::cmd_type      cmd
);
   btpc_pkg::state_type state_ff, state_in;
   logic div_wait_ff, div_wait_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= btpc_pkg::ST_IDLE;
         div_wait_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         div_wait_ff <= div_wait_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      div_wait_in = div_wait_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd.step = state_ff;
      cmd.div_start = 1'b0;
      cmd.load_req = 1'b0;
      unique case (state_ff)
         btpc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in = req_func ? btpc_pkg::ST_P_B6 : btpc_pkg::ST_T_X1;
            end
         end
         btpc_pkg::ST_T_DIV, btpc_pkg::ST_P_DIV: begin
            if (!div_wait_ff) begin
               if (status.div_zero) begin
                  state_in = btpc_pkg::ST_OUT;
               end else begin
                  cmd.div_start = 1'b1;
                  div_wait_in = 1'b1;
               end
            end else if (status.div_done) begin
               div_wait_in = 1'b0;
               state_in = (state_ff == btpc_pkg::ST_T_DIV) ? btpc_pkg::ST_T_B5
                                                           : btpc_pkg::ST_P_Q;
            end
         end
         btpc_pkg::ST_T_B5, btpc_pkg::ST_P_FIN: state_in = btpc_pkg::ST_OUT;
         btpc_pkg::ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) state_in = btpc_pkg::ST_IDLE;
         end
         default: state_in = btpc_pkg::state_type'(state_ff + 5'd1);
      endcase
   end
endmodule

>>> sv/btpc_dp.sv
`timescale 1ns / 1ps
module btpc_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [3:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   input  logic                 req_func,
   input  logic [18:0]          req_raw_reading,
   input  btpc_pkg::cmd_type    cmd,
   output btpc_pkg::status_type status,
   output logic                 rsp_is_pressure,
   output logic [31:0]          rsp_value,
   output logic                 rsp_div_error
);
   logic [15:0] ac1_ff, ac2_ff, ac3_ff, ac4_ff, b1_ff, b2_ff;
   logic [31:0] ac56_ff, mcmd_ff;
   logic [31:0] b5_ff, b5_in;
   logic [31:0] raw_ff, b6_ff, sq_ff, xa_ff, xb_ff, b3_ff, b4_ff, b7_ff, p_ff;
   logic [31:0] acc_ff, acc_in;
   logic        kind_ff, err_ff;
   logic [31:0] ma_ff, mb_ff;
   logic        neg_ff;
   logic [31:0] ma_in, mb_in;
   logic        neg_in;
   logic [31:0] xa_in, xb_in, b3_in, b4_in, b7_in, p_in, b6_in, sq_in;
   logic        err_in;
   logic [31:0] mul_a, mul_b, mul_p;
   logic [31:0] quo;
   logic        div_done;
   logic [31:0] t_a, t_b;

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] asr(input logic [31:0] x, input int n);
      return 32'($signed(x) >>> n);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         ac1_ff <= '0; ac2_ff <= '0; ac3_ff <= '0; ac4_ff <= '0;
         b1_ff <= '0; b2_ff <= '0; ac56_ff <= '0; mcmd_ff <= '0;
         b5_ff <= '0;
      end else begin
         b5_ff <= b5_in;
         if (csr_we) begin
            case (csr_index)
               btpc_pkg::REG_AC1:  ac1_ff <= csr_wdata[15:0];
               btpc_pkg::REG_AC2:  ac2_ff <= csr_wdata[15:0];
               btpc_pkg::REG_AC3:  ac3_ff <= csr_wdata[15:0];
               btpc_pkg::REG_AC4:  ac4_ff <= csr_wdata[15:0];
               btpc_pkg::REG_B1:   b1_ff <= csr_wdata[15:0];
               btpc_pkg::REG_B2:   b2_ff <= csr_wdata[15:0];
               btpc_pkg::REG_AC56: ac56_ff <= csr_wdata;
               btpc_pkg::REG_MCMD: mcmd_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // one shared 32x32 low-word multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.step)
         btpc_pkg::ST_T_X1: begin mul_a = raw_ff - {16'd0, ac56_ff[15:0]};
                                  mul_b = {16'd0, ac56_ff[31:16]}; end
         btpc_pkg::ST_P_SQ: begin mul_a = b6_ff; mul_b = b6_ff; end
         btpc_pkg::ST_P_X1: begin mul_a = sx16(b2_ff); mul_b = sq_ff; end
         btpc_pkg::ST_P_X2: begin mul_a = sx16(ac2_ff); mul_b = b6_ff; end
         btpc_pkg::ST_P_Y1: begin mul_a = sx16(ac3_ff); mul_b = b6_ff; end
         btpc_pkg::ST_P_Y2: begin mul_a = sx16(b1_ff); mul_b = sq_ff; end
         btpc_pkg::ST_P_B4: begin mul_a = {16'd0, ac4_ff}; mul_b = xa_ff + 32'd32768; end
         btpc_pkg::ST_P_B7: begin mul_a = raw_ff - b3_ff;
                                  mul_b = 32'd50000 >> btpc_pkg::OSS_BITS; end
         btpc_pkg::ST_P_Z1: begin mul_a = asr(p_ff, 8); mul_b = asr(p_ff, 8); end
         btpc_pkg::ST_P_Z2: begin mul_a = acc_ff; mul_b = 32'd3038; end
         btpc_pkg::ST_P_Z3: begin mul_a = 32'd0 - 32'd7357; mul_b = p_ff; end
         default: ;
      endcase
   end
   assign mul_p = mul_a * mul_b;

   always_comb begin
      b5_in = b5_ff; acc_in = acc_ff; xa_in = xa_ff; xb_in = xb_ff;
      b3_in = b3_ff; b4_in = b4_ff; b7_in = b7_ff; p_in = p_ff;
      b6_in = b6_ff; sq_in = sq_ff; err_in = err_ff;
      ma_in = ma_ff; mb_in = mb_ff; neg_in = neg_ff;
      t_a = '0; t_b = '0;
      case (cmd.step)
         btpc_pkg::ST_IDLE: err_in = 1'b0;
         btpc_pkg::ST_T_X1: xa_in = asr(mul_p, 15);
         btpc_pkg::ST_T_D: begin
            t_a = {{5{mcmd_ff[31]}}, mcmd_ff[31:16], 11'd0};
            t_b = xa_ff + sx16(mcmd_ff[15:0]);
            neg_in = t_a[31] ^ t_b[31];
            ma_in = t_a[31] ? 32'd0 - t_a : t_a;
            mb_in = t_b[31] ? 32'd0 - t_b : t_b;
            err_in = (t_b == 32'd0);
         end
         btpc_pkg::ST_T_B5: begin
            b5_in = xa_ff + (neg_ff ? 32'd0 - quo : quo);
            acc_in = asr(b5_in + 32'd8, 4);
         end
         btpc_pkg::ST_P_B6: b6_in = b5_ff - 32'd4000;
         btpc_pkg::ST_P_SQ: sq_in = asr(mul_p, 12);
         btpc_pkg::ST_P_X1: xa_in = asr(mul_p, 11);
         btpc_pkg::ST_P_X2: xb_in = asr(mul_p, 11);
         btpc_pkg::ST_P_B3:
            b3_in = asr((((sx16(ac1_ff) << 2) + xa_ff + xb_ff) << btpc_pkg::OSS_BITS)
                        + 32'd2, 2);
         btpc_pkg::ST_P_Y1: xa_in = asr(mul_p, 13);
         btpc_pkg::ST_P_Y2: xb_in = asr(mul_p, 16);
         btpc_pkg::ST_P_X3: xa_in = asr(xa_ff + xb_ff + 32'd2, 2);
         btpc_pkg::ST_P_B4: begin
            b4_in = mul_p >> 15;
            err_in = (b4_in == 32'd0);
         end
         btpc_pkg::ST_P_B7: begin
            b7_in = mul_p;
            neg_in = 1'b0;
            mb_in = b4_ff;
            ma_in = mul_p[31] ? mul_p : (mul_p << 1);
         end
         btpc_pkg::ST_P_Q: p_in = b7_ff[31] ? (quo << 1) : quo;
         btpc_pkg::ST_P_Z1: acc_in = mul_p;
         btpc_pkg::ST_P_Z2: acc_in = asr(mul_p, 16);
         btpc_pkg::ST_P_Z3: xb_in = asr(mul_p, 16);
         btpc_pkg::ST_P_FIN: acc_in = p_ff + asr(acc_ff + xb_ff + 32'd3791, 4);
         default: ;
      endcase
      if (cmd.step == btpc_pkg::ST_OUT && err_ff) acc_in = '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         raw_ff <= {13'd0, req_raw_reading};
         kind_ff <= req_func;
      end
      acc_ff <= acc_in; xa_ff <= xa_in; xb_ff <= xb_in; b3_ff <= b3_in;
      b4_ff <= b4_in; b7_ff <= b7_in; p_ff <= p_in; b6_ff <= b6_in;
      sq_ff <= sq_in; err_ff <= err_in; ma_ff <= ma_in; mb_ff <= mb_in;
      neg_ff <= neg_in;
   end

   btpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (ma_ff),
      .divisor  (mb_ff),
      .quotient (quo),
      .done     (div_done)
   );

   assign status.div_done = div_done;
   assign status.div_zero = err_ff;
   assign rsp_is_pressure = kind_ff;
   assign rsp_value = err_ff ? 32'd0 : acc_ff;
   assign rsp_div_error = err_ff;
endmodule

>>> sv/baro_temp_pressure_compensation.sv
`timescale 1ns / 1ps
// Integer barometric compensation. Temperature and pressure beats both use the 32-step
// restoring divider shared by both paths; a zero divisor skips the divider and returns its
// error result directly. One beat is in flight at a time: the result is held until taken
// and the next beat is accepted in the cycle after the result is taken.
module baro_temp_pressure_compensation (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [3:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // raw_reading[18:0], zero pad
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // value[31:0], div_error, zero pad
   output logic        rsp_tuser    // is_pressure
);
   btpc_pkg::cmd_type    cmd;
   btpc_pkg::status_type status;
   logic [31:0] value;
   logic        div_error;

   btpc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .req_func   (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   btpc_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_func        (req_tuser),
      .req_raw_reading (req_tdata[18:0]),
      .cmd             (cmd),
      .status          (status),
      .rsp_is_pressure (rsp_tuser),
      .rsp_value       (value),
      .rsp_div_error   (div_error)
   );

   assign rsp_tdata = {7'd0, div_error, value};

`ifndef ASSERT_OFF
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("accept while result pending");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[32]) |-> (rsp_tdata[31:0] == 32'd0))
      else $error("error result not zero");
   a_start_once: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !cmd.div_start) else $error("divider restarted");
`endif
endmodule
